>>> src/temp_scratchpad_checker_top_defines.svh
// Assertion macros used by the checker file
`ifndef TEMP_SCRATCHPAD_CHECKER_TOP_DEFINES_SVH
`define TEMP_SCRATCHPAD_CHECKER_TOP_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define TSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define TSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also watches reset itself
`define TSC_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tsc_pkg.sv
package tsc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DECI_W  = 16;
    localparam int unsigned PROD_W  = 20;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

    // status codes
    localparam logic ST_CRC_OK  = 1'b0;
    localparam logic ST_CRC_BAD = 1'b1;

    typedef logic [BYTE_W-1:0]        t_byte;
    typedef logic signed [DECI_W-1:0] t_deci;

    typedef struct packed {
        logic  status;
        t_deci temp;
    } t_result;

    // reflected CRC-8, one byte, LSB first
    function automatic t_byte crc8_byte(input t_byte crc_in, input t_byte data);
        t_byte c;
        t_byte d;
        logic  fb;
        c = crc_in;
        d = data;
        for (int k = 0; k < BYTE_W; k++) begin
            fb = c[0] ^ d[0];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

>>> src/temp_scratchpad_checker_top.sv
// Channel   Dir  tdata                        tuser
// s_axis    in   [7:0] scratch_byte           [0] start_req
// m_axis    out  [15:0] temperature_deci_c    [0] status
//
// One byte per cycle sustained while the result register is free to advance.
// Latency is set by the input register and the result register around the CRC step.
// Reset clears the count, CRC and held temperature bytes.
// A stalled result holds the byte pipe; bytes that give no result still need
// the result register free to advance.
module temp_scratchpad_checker_top
    import tsc_pkg::*;
#(
    parameter int unsigned SCRATCH_BYTES = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] scratch_byte
    input  logic        s_axis_tuser,   // [0] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] temperature_deci_c
    output logic        m_axis_tuser    // [0] status
);

    logic    in_valid;
    t_byte   in_byte;
    logic    in_start;
    logic    out_space;
    logic    step;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign step = in_valid && out_space;

    tsc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_start (s_axis_tuser),
        .i_take  (step),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_start (in_start)
    );

    tsc_core #(
        .SCRATCH_BYTES (SCRATCH_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .i_start     (in_start),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tsc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_space (out_space),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.temp;
    assign m_axis_tuser = out_res.status;

endmodule

>>> src/tsc_in_stage.sv
module tsc_in_stage
    import tsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_byte i_byte,
    input  logic  i_start,
    input  logic  i_take,
    output logic  o_valid,
    output t_byte o_byte,
    output logic  o_start
);

    logic  r_valid;
    t_byte r_byte;
    logic  r_start;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte  <= i_byte;
            r_start <= i_start;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_start = r_start;

endmodule

>>> src/tsc_core.sv
module tsc_core
    import tsc_pkg::*;
#(
    parameter int unsigned SCRATCH_BYTES = 9
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_byte   i_byte,
    input  logic    i_start,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam int unsigned IDX_W = $clog2(SCRATCH_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCRATCH_BYTES - 1);

    logic [IDX_W-1:0] r_idx;
    t_byte            r_crc;
    t_byte            r_lo;
    t_byte            r_hi;

    logic [IDX_W-1:0]         idx_eff;
    t_byte                    crc_base;
    logic                     is_check;
    logic                     bad;
    logic signed [PROD_W-1:0] raw_ext;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_adj;

    always_comb begin
        idx_eff  = i_start ? '0 : r_idx;
        crc_base = (idx_eff == '0) ? '0 : r_crc;
        is_check = (idx_eff >= LAST_IDX);
        bad      = (i_byte != crc_base);
        // raw*10 as (raw<<3)+(raw<<1); bias negatives so the shift truncates toward zero
        raw_ext  = PROD_W'($signed({r_hi, r_lo}));
        prod     = (raw_ext <<< 3) + (raw_ext <<< 1);
        prod_adj = prod + (prod[PROD_W-1] ? PROD_W'(15) : PROD_W'(0));
    end

    assign o_res_valid  = i_step && is_check;
    assign o_res.status = bad ? ST_CRC_BAD : ST_CRC_OK;
    assign o_res.temp   = bad ? '0 : t_deci'(prod_adj[PROD_W-1:4]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_crc <= '0;
            r_lo  <= '0;
            r_hi  <= '0;
        end else if (i_step) begin
            if (is_check) begin
                r_idx <= '0;
                r_crc <= '0;
            end else begin
                if (idx_eff == IDX_W'(0)) begin
                    r_lo <= i_byte;
                end else if (idx_eff == IDX_W'(1)) begin
                    r_hi <= i_byte;
                end
                r_crc <= crc8_byte(crc_base, i_byte);
                r_idx <= idx_eff + IDX_W'(1);
            end
        end
    end

endmodule

>>> src/tsc_out_stage.sv
module tsc_out_stage
    import tsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_space,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // room next edge if empty or the waiting beat leaves now
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> src/tsc_checker.sv
`include "temp_scratchpad_checker_top_defines.svh"

module tsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a failed check carries no temperature
    `TSC_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'd0, "mismatch beat with nonzero temperature")

    // scaled reading stays within -20480 .. 20479
    `TSC_ASSERT_NOW(a_range, i_clk, i_rst_n, m_axis_tvalid, ($signed(m_axis_tdata) <= 16'sd20479) && ($signed(m_axis_tdata) >= -16'sd20480), "temperature out of range")

    `TSC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // no result straight out of reset
    `TSC_ASSERT_RST(a_rst_quiet, i_clk, !i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind temp_scratchpad_checker_top tsc_checker u_tsc_checker (.*);
